// ===== hw/rtl/pip_pkg.sv =====
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and constants of the point-in-polygon block.
// ----------------------------------------------------------------------------
package pip_pkg;

	localparam int DEF_MAX_VERTICES = 64;
	localparam int DEF_COORD_BITS   = 16;

	// fixed field widths of the channels
	localparam int IN_COORD_W = 16;
	localparam int INDEX_W    = 6;
	localparam int COUNT_W    = 7;

	// front-to-back queue
	localparam int QUEUE_DEPTH = 2;

	// request function codes
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	typedef struct packed {
		logic                  query;
		logic [INDEX_W-1:0]    index;
		logic [IN_COORD_W-1:0] x;
		logic [IN_COORD_W-1:0] y;
	} pip_cmd_t;

endpackage

// ===== hw/rtl/pip_if.sv =====
// ----------------------------------------------------------------------------
// pip_if
// Valid/ready channels of the point-in-polygon block.
// ----------------------------------------------------------------------------
interface pip_in_if;
	import pip_pkg::*;

	logic                  valid;
	logic                  ready;
	logic                  func;
	logic [INDEX_W-1:0]    vertex_index;
	logic [IN_COORD_W-1:0] vertex_x;
	logic [IN_COORD_W-1:0] vertex_y;
	logic [IN_COORD_W-1:0] point_x;
	logic [IN_COORD_W-1:0] point_y;

	modport source (output valid, func, vertex_index, vertex_x, vertex_y, point_x, point_y,
		input ready);
	modport sink (input valid, func, vertex_index, vertex_x, vertex_y, point_x, point_y,
		output ready);
endinterface

interface pip_out_if;
	logic valid;
	logic ready;
	logic inside_res;

	modport source (output valid, inside_res, input ready);
	modport sink (input valid, inside_res, output ready);
endinterface

interface pip_cfg_if;
	import pip_pkg::*;

	logic               valid;
	logic               ready;
	logic [COUNT_W-1:0] vertex_count;

	modport source (output valid, vertex_count, input ready);
	modport sink (input valid, vertex_count, output ready);
endinterface

// ===== hw/rtl/point_in_polygon_test.sv =====
// ----------------------------------------------------------------------------
// point_in_polygon_test
// Even-odd crossing test of a point against a loaded polygon vertex table.
// A query reads vertex n-1, then walks vertices 0..n-1 (n = clipped count),
// drains the crossing pipeline and posts its result; n = 0 posts outside.
// One load per cycle while no query is busy; one query at a time.
// Reset clears control and vertex_count; the vertex table stays undefined.
// ----------------------------------------------------------------------------
module point_in_polygon_test #(
	parameter int MAX_VERTICES = pip_pkg::DEF_MAX_VERTICES,
	parameter int COORD_BITS   = pip_pkg::DEF_COORD_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	pip_in_if.sink    item,
	pip_out_if.source result,
	pip_cfg_if.sink   cfg
);
	import pip_pkg::*;

	pip_cmd_t q_cmd;
	logic     q_valid;
	logic     q_pop;

	pip_front #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.q_cmd   (q_cmd),
		.q_valid (q_valid),
		.q_pop   (q_pop)
	);

	pip_back #(
		.MAX_VERTICES (MAX_VERTICES),
		.COORD_BITS   (COORD_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_cmd   (q_cmd),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.cfg     (cfg),
		.result  (result)
	);

	// back never pops an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");

	// a load never produces a result
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && !q_cmd.query) |=> !$rose(result.valid))
		else $error("result raised after a vertex load");

	// a query occupies the back end, no pop right behind it
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_cmd.query) |=> !q_pop)
		else $error("pop right after a query");

endmodule

// ===== hw/rtl/pip_ram.sv =====
// ----------------------------------------------------------------------------
// pip_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pip_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/pip_front.sv =====
// ----------------------------------------------------------------------------
// pip_front
// Accepts requests, drops loads beyond the table, queues the rest.
// ----------------------------------------------------------------------------
module pip_front #(
	parameter int MAX_VERTICES = pip_pkg::DEF_MAX_VERTICES
) (
	input  logic              clk,
	input  logic              arst_n,
	pip_in_if.sink            item,
	output pip_pkg::pip_cmd_t q_cmd,
	output logic              q_valid,
	input  logic              q_pop
);
	import pip_pkg::*;

	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	pip_cmd_t            fifo_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wptr_q;
	logic [QPTR_W-1:0]   rptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                accept;
	logic                push;
	logic                index_ok;
	pip_cmd_t            cmd_in;

	assign item.ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign accept     = item.valid && item.ready;
	assign index_ok   = int'(item.vertex_index) < MAX_VERTICES;
	assign push       = accept && ((item.func == FUNC_QUERY) || index_ok);

	always_comb begin
		cmd_in.query = (item.func == FUNC_QUERY);
		cmd_in.index = item.vertex_index;
		cmd_in.x     = (item.func == FUNC_QUERY) ? item.point_x : item.vertex_x;
		cmd_in.y     = (item.func == FUNC_QUERY) ? item.point_y : item.vertex_y;
	end

	assign q_valid = (count_q != '0);
	assign q_cmd   = fifo_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + QPTR_W'(1);
			end
			if (q_pop) begin
				rptr_q <= rptr_q + QPTR_W'(1);
			end
			if (push && !q_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (q_pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

// ===== hw/rtl/pip_back.sv =====
// ----------------------------------------------------------------------------
// pip_back
// Vertex table, edge-walk sequencer, crossing pipeline and result register.
// ----------------------------------------------------------------------------
module pip_back #(
	parameter int MAX_VERTICES = pip_pkg::DEF_MAX_VERTICES,
	parameter int COORD_BITS   = pip_pkg::DEF_COORD_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pip_pkg::pip_cmd_t q_cmd,
	input  logic              q_valid,
	output logic              q_pop,
	pip_cfg_if.sink           cfg,
	pip_out_if.source         result
);
	import pip_pkg::*;

	localparam int CW    = (COORD_BITS < IN_COORD_W) ? COORD_BITS : IN_COORD_W;
	localparam int DW    = CW + 1;
	localparam int PW    = 2 * CW + 2;
	localparam int AW    = $clog2(MAX_VERTICES);
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_WALK  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]          state_q;
	logic [COUNT_W-1:0]  vcount_q;
	logic [CNT_W-1:0]    n_eff;
	logic [AW-1:0]       start_nm1;
	logic [AW-1:0]       nm1_q;
	logic [AW-1:0]       cnt_q;
	logic signed [CW-1:0] px_q;
	logic signed [CW-1:0] py_q;
	logic                odd_q;
	logic                res_valid_q;
	logic                res_q;
	logic                out_free;

	logic                issue_first;
	logic                issue_walk;
	logic                issue_last;
	logic                ram_we;
	logic                ram_re;
	logic [AW-1:0]       ram_raddr;
	logic [2*CW-1:0]     ram_rdata;

	logic                v_s1, first_s1, last_s1;
	logic signed [CW-1:0] prev_x_q, prev_y_q;
	logic signed [CW-1:0] cur_x, cur_y;

	logic                v_s2, last_s2, strad_s2, dneg_s2;
	logic signed [DW-1:0] a_s2, b_s2, c_s2, d_s2;

	logic                v_s3, last_s3, strad_s3, dneg_s3;
	logic signed [PW-1:0] p1_s3, p2_s3;
	logic                toggle;

	// effective vertex count, clipped to the table size
	always_comb begin
		if (int'(vcount_q) > MAX_VERTICES) begin
			n_eff = CNT_W'(MAX_VERTICES);
		end else begin
			n_eff = CNT_W'(vcount_q);
		end
	end
	assign start_nm1 = AW'(n_eff - CNT_W'(1));

	assign out_free    = !res_valid_q || result.ready;
	assign q_pop       = (state_q == ST_IDLE) && q_valid;
	assign issue_first = q_pop && q_cmd.query && (n_eff != '0);
	assign issue_walk  = (state_q == ST_WALK);
	assign issue_last  = issue_walk && (cnt_q == nm1_q);

	assign ram_we    = q_pop && !q_cmd.query;
	assign ram_re    = issue_first || issue_walk;
	assign ram_raddr = issue_walk ? cnt_q : start_nm1;

	pip_ram #(
		.WIDTH (2 * CW),
		.DEPTH (MAX_VERTICES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(q_cmd.index)),
		.wdata ({q_cmd.x[CW-1:0], q_cmd.y[CW-1:0]}),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign cur_x = ram_rdata[2*CW-1:CW];
	assign cur_y = ram_rdata[CW-1:0];

	// crossing lies left of the point: sign of d decides the compare direction
	assign toggle = strad_s3 && (dneg_s3 ? (p1_s3 > p2_s3) : (p1_s3 < p2_s3));

	assign cfg.ready         = 1'b1;
	assign result.valid      = res_valid_q;
	assign result.inside_res = res_q;

	// datapath payload
	always_ff @(posedge clk) begin
		if (q_pop && q_cmd.query) begin
			px_q  <= q_cmd.x[CW-1:0];
			py_q  <= q_cmd.y[CW-1:0];
			nm1_q <= start_nm1;
		end
		if (v_s1) begin
			prev_x_q <= cur_x;
			prev_y_q <= cur_y;
		end
		// prev holds vertex j, the RAM output vertex i
		strad_s2 <= (cur_y < py_q) != (prev_y_q < py_q);
		dneg_s2  <= prev_y_q < cur_y;
		a_s2     <= {py_q[CW-1], py_q} - {cur_y[CW-1], cur_y};
		b_s2     <= {prev_x_q[CW-1], prev_x_q} - {cur_x[CW-1], cur_x};
		c_s2     <= {px_q[CW-1], px_q} - {cur_x[CW-1], cur_x};
		d_s2     <= {prev_y_q[CW-1], prev_y_q} - {cur_y[CW-1], cur_y};
		strad_s3 <= strad_s2;
		dneg_s3  <= dneg_s2;
		p1_s3    <= PW'(a_s2) * PW'(b_s2);
		p2_s3    <= PW'(c_s2) * PW'(d_s2);
		if (state_q == ST_DONE && out_free) begin
			res_q <= odd_q;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			vcount_q    <= '0;
			cnt_q       <= '0;
			odd_q       <= 1'b0;
			res_valid_q <= 1'b0;
			v_s1        <= 1'b0;
			first_s1    <= 1'b0;
			last_s1     <= 1'b0;
			v_s2        <= 1'b0;
			last_s2     <= 1'b0;
			v_s3        <= 1'b0;
			last_s3     <= 1'b0;
		end else begin
			if (cfg.valid) begin
				vcount_q <= cfg.vertex_count;
			end

			v_s1     <= ram_re;
			first_s1 <= issue_first;
			last_s1  <= issue_last;
			v_s2     <= v_s1 && !first_s1;
			last_s2  <= last_s1;
			v_s3     <= v_s2;
			last_s3  <= last_s2;

			if (v_s3 && toggle) begin
				odd_q <= !odd_q;
			end

			// in ST_DONE a taken result is replaced by the next one below
			if (result.valid && result.ready && (state_q != ST_DONE)) begin
				res_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (q_pop && q_cmd.query) begin
						odd_q <= 1'b0;
						cnt_q <= '0;
						state_q <= (n_eff == '0) ? ST_DONE : ST_WALK;
					end
				end
				ST_WALK: begin
					cnt_q <= cnt_q + AW'(1);
					if (issue_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (v_s3 && last_s3) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
